@@ sv/laser_scan_polar_to_cartesian_core_macros.svh @@
// assertion macros for the laser scan polar to cartesian core
`ifndef LASER_SCAN_POLAR_TO_CARTESIAN_CORE_MACROS_SVH
`define LASER_SCAN_POLAR_TO_CARTESIAN_CORE_MACROS_SVH

// same-cycle implication
`define LSPC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LSPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/lspc_pkg.sv @@
// shared types and constants for the laser scan polar to cartesian core
package lspc_pkg;

   localparam int RANGE_W    = 16;
   localparam int CLASS_W    = 2;
   localparam int ANGLE_W    = 16;
   localparam int COORD_W    = 17;
   localparam int QUAD_W     = 2;
   localparam int POS_W      = 14;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int TRIG_FRAC_BITS_DEF = 15;
   localparam int QUEUE_DEPTH_DEF    = 4;

   localparam logic [30:0] Q30_ONE      = 31'h4000_0000;
   localparam logic [30:0] HALF_PI_Q30  = 31'd1686629713;
   localparam logic [14:0] QUARTER_TURN = 15'd16384;

   localparam logic [RANGE_W-1:0] MAX_RANGE_RESET = 16'hFFFF;

   localparam int TAYLOR_TERMS = 5;
   localparam logic [6:0] TAYLOR_DIV [TAYLOR_TERMS] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_ANGLE  = 3'd0,
      CSR_ANGLE_STEP   = 3'd1,
      CSR_MIN_RANGE_MM = 3'd2,
      CSR_MAX_RANGE_MM = 3'd3,
      CSR_INF_AS_MAX   = 3'd4
   } csr_reg_type;

   typedef enum logic [CLASS_W-1:0] {
      CLS_FINITE  = 2'd0,
      CLS_POS_INF = 2'd1,
      CLS_NAN     = 2'd2,
      CLS_NEG_INF = 2'd3
   } range_class_type;

   typedef struct packed {
      logic               ok;
      logic [RANGE_W-1:0] range;
      logic [QUAD_W-1:0]  quad;
   } meta_type;

   typedef struct packed {
      meta_type         meta;
      logic [POS_W-1:0] pos;
   } beam_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

endpackage

@@ sv/lspc_if.sv @@
// channel interfaces: beam request, point response, register write
interface lspc_req_if;
   logic                                valid;
   logic                                ready;
   logic [lspc_pkg::RANGE_W-1:0]        range_mm;
   logic [lspc_pkg::CLASS_W-1:0]        range_class;
   logic                                scan_start;

   modport source (output valid, output range_mm, output range_class, output scan_start,
                   input ready);
   modport sink   (input valid, input range_mm, input range_class, input scan_start,
                   output ready);
endinterface

interface lspc_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [lspc_pkg::COORD_W-1:0] point_x;
   logic signed [lspc_pkg::COORD_W-1:0] point_y;
   logic                                point_valid;

   modport source (output valid, output point_x, output point_y, output point_valid,
                   input ready);
   modport sink   (input valid, input point_x, input point_y, input point_valid,
                   output ready);
endinterface

interface lspc_csr_if;
   logic                                valid;
   logic                                ready;
   logic [lspc_pkg::CSR_IDX_W-1:0]      index;
   logic [lspc_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/lspc_front.sv @@
// front end: config registers, beam angle tracking and range classification
module lspc_front (
   input  logic                    clock,
   input  logic                    reset,
   lspc_req_if.sink                req_bus,
   lspc_csr_if.sink                csr_bus,
   input  lspc_pkg::fifo_stat_type q_stat,
   output logic                    q_push,
   output lspc_pkg::beam_type      q_entry
);
   import lspc_pkg::*;

   logic [ANGLE_W-1:0] start_angle_ff, start_angle_in;
   logic [ANGLE_W-1:0] angle_step_ff, angle_step_in;
   logic [RANGE_W-1:0] min_range_ff, min_range_in;
   logic [RANGE_W-1:0] max_range_ff, max_range_in;
   logic               inf_as_max_ff, inf_as_max_in;
   logic [ANGLE_W-1:0] beam_angle_ff, beam_angle_in;

   logic               csr_wr;
   logic [ANGLE_W-1:0] ang;
   logic [RANGE_W-1:0] rng;
   logic               ok;

   assign csr_bus.ready = 1'b1;
   assign csr_wr        = csr_bus.valid && csr_bus.ready;

   assign req_bus.ready = !q_stat.full;
   assign q_push        = req_bus.valid && req_bus.ready;

   always_comb begin
      start_angle_in = start_angle_ff;
      angle_step_in  = angle_step_ff;
      min_range_in   = min_range_ff;
      max_range_in   = max_range_ff;
      inf_as_max_in  = inf_as_max_ff;
      if (csr_wr) begin
         case (csr_reg_type'(csr_bus.index))
            CSR_START_ANGLE:  start_angle_in = csr_bus.data;
            CSR_ANGLE_STEP:   angle_step_in  = csr_bus.data;
            CSR_MIN_RANGE_MM: min_range_in   = csr_bus.data;
            CSR_MAX_RANGE_MM: max_range_in   = csr_bus.data;
            CSR_INF_AS_MAX:   inf_as_max_in  = csr_bus.data[0];
            default:          ;
         endcase
      end
   end

   // angle of this beam, next angle follows it by one step
   assign ang           = req_bus.scan_start ? start_angle_ff : beam_angle_ff;
   assign beam_angle_in = q_push ? ang + angle_step_ff : beam_angle_ff;

   always_comb begin
      rng = req_bus.range_mm;
      ok  = 1'b0;
      case (range_class_type'(req_bus.range_class))
         CLS_FINITE: ok = 1'b1;
         CLS_POS_INF: begin
            if (inf_as_max_ff && (max_range_ff != '0)) begin
               rng = max_range_ff - 16'd1;
               ok  = 1'b1;
            end
         end
         default: ok = 1'b0;
      endcase
      if ((rng < min_range_ff) || (rng > max_range_ff)) begin
         ok = 1'b0;
      end
   end

   always_comb begin
      q_entry.meta.ok    = ok;
      q_entry.meta.range = rng;
      q_entry.meta.quad  = ang[ANGLE_W-1 -: QUAD_W];
      q_entry.pos        = ang[POS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_angle_ff <= '0;
         angle_step_ff  <= '0;
         min_range_ff   <= '0;
         max_range_ff   <= MAX_RANGE_RESET;
         inf_as_max_ff  <= 1'b0;
         beam_angle_ff  <= '0;
      end else begin
         start_angle_ff <= start_angle_in;
         angle_step_ff  <= angle_step_in;
         min_range_ff   <= min_range_in;
         max_range_ff   <= max_range_in;
         inf_as_max_ff  <= inf_as_max_in;
         beam_angle_ff  <= beam_angle_in;
      end
   end

endmodule

@@ sv/lspc_queue.sv @@
// short beam queue between front end and trig pipeline
module lspc_queue #(
   parameter int DEPTH = lspc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  lspc_pkg::beam_type      push_data,
   input  logic                    pop,
   output lspc_pkg::beam_type      head,
   output lspc_pkg::fifo_stat_type stat
);
   import lspc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   beam_type         entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign stat.full  = (cnt_ff == CNT_W'(DEPTH));
   assign stat.empty = (cnt_ff == '0);
   assign head       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ sv/lspc_back.sv @@
// back end: pipelined sine/cosine, range scaling and output register
module lspc_back #(
   parameter int TRIG_FRAC_BITS = lspc_pkg::TRIG_FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  lspc_pkg::fifo_stat_type q_stat,
   input  lspc_pkg::beam_type      q_head,
   output logic                    q_pop,
   lspc_rsp_if.source              rsp_bus
);
   import lspc_pkg::*;

   localparam int TW      = TRIG_FRAC_BITS + 1;
   localparam int PW      = RANGE_W + TW;
   localparam int ST_X2   = 1;
   localparam int ST_ITER = 2;
   localparam int ST_SIN  = ST_ITER + 3 * TAYLOR_TERMS;
   localparam int NSTG    = ST_SIN + 3;

   logic                      adv;
   logic [NSTG-1:0]           vld_ff;
   meta_type                  meta_ff [NSTG];

   logic [30:0]               x_in  [2];
   logic [31:0]               x2_in [2];
   logic [31:0]               s_in  [2];
   logic [TW-1:0]             trig_in [2];
   logic [30:0]               x_ff  [ST_SIN][2];
   logic [31:0]               x2_ff [ST_X2:ST_SIN-1][2];
   logic [31:0]               s_ff  [2];
   logic [TW-1:0]             trig_ff [2];

   logic [31:0]               n_ff  [TAYLOR_TERMS][2];
   logic [31:0]               nq_ff [TAYLOR_TERMS][2];
   logic [29:0]               qe_ff [TAYLOR_TERMS][2];
   logic [30:0]               t_ff  [TAYLOR_TERMS][2];

   logic [QUAD_W-1:0]         mquad;
   logic [TW-1:0]             cmag, smag;
   logic [PW-1:0]             cprod, sprod;
   logic [RANGE_W-1:0]        cv_in, sv_in, cv_ff, sv_ff;

   logic                      cneg, sneg;
   logic signed [COORD_W-1:0] px_in, py_in, px_ff, py_ff;
   logic                      pv_ff;
   logic                      out_vld_ff;

   assign adv   = !out_vld_ff || rsp_bus.ready;
   assign q_pop = adv && !q_stat.empty;

   // lane 0 is sin of the position in the quadrant, lane 1 sin of its complement
   for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [14:0] a;
      logic [45:0] xprod;
      logic [61:0] x2prod;
      logic [61:0] sinprod;
      logic [31:0] sc;
      logic [31:0] rsum;

      if (l == 0) begin : g_pos
         assign a = {1'b0, q_head.pos};
      end else begin : g_cmp
         assign a = QUARTER_TURN - {1'b0, q_head.pos};
      end

      assign xprod   = 46'(a) * 46'(HALF_PI_Q30);
      assign x_in[l] = xprod[44:14];

      assign x2prod   = 62'(x_ff[0][l]) * 62'(x_ff[0][l]);
      assign x2_in[l] = x2prod[61:30];

      assign sinprod = 62'(x_ff[ST_SIN-1][l]) * 62'(t_ff[TAYLOR_TERMS-1][l]);
      assign s_in[l] = sinprod[61:30];

      assign sc         = (s_ff[l] > 32'(Q30_ONE)) ? 32'(Q30_ONE) : s_ff[l];
      assign rsum       = sc + (32'd1 << (29 - TRIG_FRAC_BITS));
      assign trig_in[l] = TW'(rsum >> (30 - TRIG_FRAC_BITS));
   end

   // nested series: t = 1 - (x2 * t) / d, one term per three stages
   for (genvar k = 0; k < TAYLOR_TERMS; k++) begin : g_iter
      localparam int          N_ST  = ST_ITER + 3 * k;
      localparam logic [6:0]  DIV   = TAYLOR_DIV[k];
      localparam logic [29:0] RECIP = 30'((64'd1 << 32) / 64'(DIV));

      for (genvar l = 0; l < 2; l++) begin : g_term
         logic [30:0] t_cur;
         logic [62:0] nprod;
         logic [61:0] qprod;
         logic [36:0] qd;
         logic [31:0] rem;
         logic [29:0] q_fix;
         logic [31:0] n_in;
         logic [29:0] qe_in;
         logic [30:0] t_in;

         if (k == 0) begin : g_first
            assign t_cur = Q30_ONE;
         end else begin : g_next
            assign t_cur = t_ff[k-1][l];
         end

         assign nprod = 63'(x2_ff[N_ST-1][l]) * 63'(t_cur);
         assign n_in  = nprod[61:30];

         assign qprod = 62'(n_ff[k][l]) * 62'(RECIP);
         assign qe_in = qprod[61:32];

         // reciprocal estimate is at most one low
         assign qd    = 37'(qe_ff[k][l]) * 37'(DIV);
         assign rem   = nq_ff[k][l] - qd[31:0];
         assign q_fix = qe_ff[k][l] + 30'(rem >= 32'(DIV));
         assign t_in  = Q30_ONE - 31'(q_fix);

         always_ff @(posedge clock) begin
            if (adv) begin
               n_ff[k][l]  <= n_in;
               qe_ff[k][l] <= qe_in;
               nq_ff[k][l] <= n_ff[k][l];
               t_ff[k][l]  <= t_in;
            end
         end
      end
   end

   // quadrant folding and range scaling
   assign mquad = meta_ff[NSTG-2].quad;
   assign smag  = mquad[0] ? trig_ff[1] : trig_ff[0];
   assign cmag  = mquad[0] ? trig_ff[0] : trig_ff[1];
   assign cprod = PW'(meta_ff[NSTG-2].range) * PW'(cmag) + (PW'(1) << (TRIG_FRAC_BITS - 1));
   assign sprod = PW'(meta_ff[NSTG-2].range) * PW'(smag) + (PW'(1) << (TRIG_FRAC_BITS - 1));
   assign cv_in = RANGE_W'(cprod >> TRIG_FRAC_BITS);
   assign sv_in = RANGE_W'(sprod >> TRIG_FRAC_BITS);

   assign cneg  = meta_ff[NSTG-1].quad[1] ^ meta_ff[NSTG-1].quad[0];
   assign sneg  = meta_ff[NSTG-1].quad[1];

   always_comb begin
      px_in = '0;
      py_in = '0;
      if (meta_ff[NSTG-1].ok) begin
         px_in = cneg ? COORD_W'(0) - {1'b0, cv_ff} : {1'b0, cv_ff};
         py_in = sneg ? COORD_W'(0) - {1'b0, sv_ff} : {1'b0, sv_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff     <= {vld_ff[NSTG-2:0], q_pop};
         out_vld_ff <= vld_ff[NSTG-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         meta_ff[0] <= q_head.meta;
         for (int j = 1; j < NSTG; j++) begin
            meta_ff[j] <= meta_ff[j-1];
         end
         x_ff[0] <= x_in;
         for (int j = 1; j < ST_SIN; j++) begin
            x_ff[j] <= x_ff[j-1];
         end
         x2_ff[ST_X2] <= x2_in;
         for (int j = ST_X2 + 1; j < ST_SIN; j++) begin
            x2_ff[j] <= x2_ff[j-1];
         end
         s_ff    <= s_in;
         trig_ff <= trig_in;
         cv_ff   <= cv_in;
         sv_ff   <= sv_in;
         px_ff   <= px_in;
         py_ff   <= py_in;
         pv_ff   <= meta_ff[NSTG-1].ok;
      end
   end

   assign rsp_bus.valid       = out_vld_ff;
   assign rsp_bus.point_x     = px_ff;
   assign rsp_bus.point_y     = py_ff;
   assign rsp_bus.point_valid = pv_ff;

endmodule

@@ sv/laser_scan_polar_to_cartesian_core.sv @@
// top level of the laser scan polar to cartesian core
// Takes one range beat per clock while req_bus is ready and returns one point
// beat per beam, in order. A beat accepted on req_bus is registered into the
// beam queue, then passes twenty stages of the shared sine/cosine pipeline
// (angle scaling, square, five series terms of three stages each, final
// product, rounding, range scaling) and the output register before it comes
// out on rsp_bus. The pipeline sustains one beat per clock; a stall on rsp_bus
// freezes it, and req_bus keeps accepting until the QUEUE_DEPTH-beat queue is
// full. Register writes on csr_bus are always taken and belong in idle
// periods. No clearing pass follows reset.
module laser_scan_polar_to_cartesian_core #(
   parameter int TRIG_FRAC_BITS = lspc_pkg::TRIG_FRAC_BITS_DEF,
   parameter int QUEUE_DEPTH    = lspc_pkg::QUEUE_DEPTH_DEF
) (
   input logic        clock,
   input logic        reset,
   lspc_req_if.sink   req_bus,
   lspc_rsp_if.source rsp_bus,
   lspc_csr_if.sink   csr_bus
);
   import lspc_pkg::*;

   fifo_stat_type q_stat;
   beam_type      q_entry;
   beam_type      q_head;
   logic          q_push;
   logic          q_pop;

   lspc_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .csr_bus (csr_bus),
      .q_stat  (q_stat),
      .q_push  (q_push),
      .q_entry (q_entry)
   );

   lspc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_entry),
      .pop       (q_pop),
      .head      (q_head),
      .stat      (q_stat)
   );

   lspc_back #(
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_stat  (q_stat),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .rsp_bus (rsp_bus)
   );

endmodule

@@ sv/lspc_checker.sv @@
// port-level checker for the laser scan polar to cartesian core and its bind
`include "laser_scan_polar_to_cartesian_core_macros.svh"

module lspc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [lspc_pkg::COORD_W-1:0] rsp_point_x,
   input logic signed [lspc_pkg::COORD_W-1:0] rsp_point_y,
   input logic                                rsp_point_valid
);
   logic [15:0] outstanding_ff, outstanding_in;
   logic        req_beat, rsp_beat;

   assign req_beat       = req_valid && req_ready;
   assign rsp_beat       = rsp_valid && rsp_ready;
   assign outstanding_in = outstanding_ff + 16'(req_beat) - 16'(rsp_beat);

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   `LSPC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_point_x) && $stable(rsp_point_y) && $stable(rsp_point_valid), "rsp beat changed while stalled")
   `LSPC_ASSERT_IMPL(a_rej_zero, clock, reset, rsp_valid && !rsp_point_valid, rsp_point_x == 0 && rsp_point_y == 0, "rejected point with nonzero coordinates")
   `LSPC_ASSERT_IMPL(a_no_extra, clock, reset, rsp_valid, outstanding_ff != 0, "rsp beat without a pending req beat")
   `LSPC_ASSERT_NEXT(a_rst_idle, clock, 1'b0, reset, !rsp_valid && req_ready, "core not idle after reset")

endmodule

bind laser_scan_polar_to_cartesian_core lspc_checker u_lspc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_point_x     (rsp_bus.point_x),
   .rsp_point_y     (rsp_bus.point_y),
   .rsp_point_valid (rsp_bus.point_valid)
);

@@ tb/testbench.sv @@
// testbench for the laser scan polar to cartesian core: table-driven and random beams vs predictor
`timescale 1ns / 1ps

module testbench;
   import lspc_pkg::*;

   localparam int FRAC_BITS   = TRIG_FRAC_BITS_DEF;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RAND_PHASES = 6;
   localparam int PHASE_BEAMS = 250;
   localparam longint unsigned ONE_Q30     = 64'd1 << 30;
   localparam longint unsigned HALF_PI_FIX = 64'd1686629713;
   localparam int unsigned     QUARTER     = 16384;
   localparam longint unsigned SERIES_DIV [5] = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic                      valid;
   } point_type;

   typedef struct packed {
      logic                    is_csr;
      csr_reg_type             csr_idx;
      logic [CSR_DATA_W-1:0]   data;
      logic [RANGE_W-1:0]      range;
      range_class_type         cls;
      logic                    start;
      logic                    fixed;
      point_type               pt;
   } plan_row_type;

   logic clock;
   logic reset;

   lspc_req_if req_bus ();
   lspc_rsp_if rsp_bus ();
   lspc_csr_if csr_bus ();

   laser_scan_polar_to_cartesian_core #(
      .TRIG_FRAC_BITS(FRAC_BITS)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   // predictor copy of the registers and beam angle
   logic [ANGLE_W-1:0] cfg_start_angle;
   logic [ANGLE_W-1:0] cfg_angle_step;
   logic [RANGE_W-1:0] cfg_min_mm;
   logic [RANGE_W-1:0] cfg_max_mm;
   logic               cfg_inf_as_max;
   logic [ANGLE_W-1:0] next_angle;

   point_type    pending_points [$];
   plan_row_type plan [$];
   int           error_count;
   int           beams_sent;
   int           points_checked;
   int           valid_points;
   int           csr_writes;
   int           cycle_count;
   bit           gap_on;
   bit           stall_on;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic longint unsigned quarter_sine(input int unsigned pos);
      longint unsigned ang_q30, sq, term, s;
      if (pos > QUARTER)
         pos = QUARTER;
      ang_q30 = (longint'(pos) * HALF_PI_FIX) >> 14;
      sq = (ang_q30 * ang_q30) >> 30;
      term = ONE_Q30;
      for (int k = 0; k < 5; k++)
         term = ONE_Q30 - ((sq * term) >> 30) / SERIES_DIV[k];
      s = (ang_q30 * term) >> 30;
      if (s > ONE_Q30)
         s = ONE_Q30;
      return (s + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
   endfunction

   function automatic logic signed [COORD_W-1:0] scale_axis(input logic [RANGE_W-1:0] r,
                                                            input longint unsigned mag,
                                                            input bit neg);
      longint unsigned v;
      v = (longint'(r) * mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      if (neg)
         v = 64'd0 - v;
      return v[COORD_W-1:0];
   endfunction

   function automatic point_type project_beam(input logic [RANGE_W-1:0] range,
                                              input range_class_type cls, input logic start);
      logic [ANGLE_W-1:0] ang;
      logic [RANGE_W-1:0] r;
      bit                 ok;
      int unsigned        pos;
      longint unsigned    sp, sq, smag, cmag;
      bit                 sneg, cneg;
      point_type          pt;
      ang = start ? cfg_start_angle : next_angle;
      next_angle = ang + cfg_angle_step;
      r = range;
      ok = 1'b0;
      if (cls == CLS_FINITE) begin
         ok = 1'b1;
      end else if (cls == CLS_POS_INF && cfg_inf_as_max && cfg_max_mm != 0) begin
         r = cfg_max_mm - 1'b1;
         ok = 1'b1;
      end
      if (ok && (r < cfg_min_mm || r > cfg_max_mm))
         ok = 1'b0;
      pt = '0;
      if (ok) begin
         pos = 32'(ang[POS_W-1:0]);
         sp = quarter_sine(pos);
         sq = quarter_sine(QUARTER - pos);
         case (ang[ANGLE_W-1 -: QUAD_W])
            2'd0: begin smag = sp; sneg = 1'b0; cmag = sq; cneg = 1'b0; end
            2'd1: begin smag = sq; sneg = 1'b0; cmag = sp; cneg = 1'b1; end
            2'd2: begin smag = sp; sneg = 1'b1; cmag = sq; cneg = 1'b1; end
            default: begin smag = sq; sneg = 1'b1; cmag = sp; cneg = 1'b0; end
         endcase
         pt.x = scale_axis(r, cmag, cneg);
         pt.y = scale_axis(r, smag, sneg);
         pt.valid = 1'b1;
      end
      return pt;
   endfunction

   function automatic plan_row_type beam_row(input logic [RANGE_W-1:0] range,
                                             input range_class_type cls, input logic start);
      plan_row_type row;
      row = '0;
      row.range = range;
      row.cls = cls;
      row.start = start;
      return row;
   endfunction

   function automatic plan_row_type fixed_row(input logic [RANGE_W-1:0] range,
                                              input range_class_type cls, input logic start,
                                              input int fx, input int fy, input logic fv);
      plan_row_type row;
      row = beam_row(range, cls, start);
      row.fixed = 1'b1;
      row.pt.x = fx[COORD_W-1:0];
      row.pt.y = fy[COORD_W-1:0];
      row.pt.valid = fv;
      return row;
   endfunction

   function automatic plan_row_type csr_row(input csr_reg_type idx,
                                            input logic [CSR_DATA_W-1:0] data);
      plan_row_type row;
      row = '0;
      row.is_csr = 1'b1;
      row.csr_idx = idx;
      row.data = data;
      return row;
   endfunction

   task automatic add_row(input plan_row_type row);
      plan.insert(plan.size(), row);
   endtask

   // entered and left at a falling edge
   task automatic drive_beam(input logic [RANGE_W-1:0] range, input range_class_type cls,
                             input logic start, input logic use_fixed,
                             input point_type fixed_pt);
      point_type pt;
      if (gap_on && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.range_mm <= range;
      req_bus.range_class <= cls;
      req_bus.scan_start <= start;
      do @(posedge clock); while (!req_bus.ready);
      pt = project_beam(range, cls, start);
      pending_points.insert(pending_points.size(), use_fixed ? fixed_pt : pt);
      beams_sent++;
      @(negedge clock);
   endtask

   task automatic wait_for_points();
      req_bus.valid <= 1'b0;
      while (pending_points.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input csr_reg_type idx, input logic [CSR_DATA_W-1:0] data);
      wait_for_points();
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= data;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         CSR_START_ANGLE:  cfg_start_angle = data;
         CSR_ANGLE_STEP:   cfg_angle_step = data;
         CSR_MIN_RANGE_MM: cfg_min_mm = data;
         CSR_MAX_RANGE_MM: cfg_max_mm = data;
         CSR_INF_AS_MAX:   cfg_inf_as_max = data[0];
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      @(negedge clock);
   endtask

   // point beat checker
   always @(posedge clock) begin
      point_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_points.size() == 0) begin
            $error("unexpected point beat x=%0d y=%0d valid=%0b",
                   rsp_bus.point_x, rsp_bus.point_y, rsp_bus.point_valid);
            error_count++;
         end else begin
            want = pending_points.pop_front();
            points_checked++;
            if (rsp_bus.point_valid)
               valid_points++;
            if (rsp_bus.point_x !== want.x) begin
               $error("point_x expected %0d got %0d", want.x, rsp_bus.point_x);
               error_count++;
            end
            if (rsp_bus.point_y !== want.y) begin
               $error("point_y expected %0d got %0d", want.y, rsp_bus.point_y);
               error_count++;
            end
            if (rsp_bus.point_valid !== want.valid) begin
               $error("point_valid expected %0b got %0b", want.valid, rsp_bus.point_valid);
               error_count++;
            end
         end
      end
   end

   // result side back-pressure
   initial begin
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         @(negedge clock);
         if (stall_on && $urandom_range(0, 9) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
      end
   end

   initial begin
      plan_row_type          row;
      logic [CSR_DATA_W-1:0] data;
      logic [RANGE_W-1:0]    range;
      range_class_type       cls;
      int                    v;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.range_mm = '0;
      req_bus.range_class = CLS_FINITE;
      req_bus.scan_start = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_START_ANGLE;
      csr_bus.data = '0;
      beams_sent = 0;
      csr_writes = 0;
      gap_on = 1'b1;
      stall_on = 1'b1;
      cfg_start_angle = '0;
      cfg_angle_step = '0;
      cfg_min_mm = '0;
      cfg_max_mm = MAX_RANGE_RESET;
      cfg_inf_as_max = 1'b0;
      next_angle = '0;

      // registers at reset: angle zero, full range
      add_row(fixed_row(16'hFFFF, CLS_FINITE, 1'b1, 65535, 0, 1'b1));
      add_row(fixed_row(16'h0000, CLS_FINITE, 1'b0, 0, 0, 1'b1));
      add_row(fixed_row(16'h1234, CLS_NAN, 1'b0, 0, 0, 1'b0));
      add_row(fixed_row(16'hFFFF, CLS_NEG_INF, 1'b0, 0, 0, 1'b0));
      add_row(fixed_row(16'h0100, CLS_POS_INF, 1'b0, 0, 0, 1'b0));
      // quarter-turn steps, range window, infinity mapped to max minus one
      add_row(csr_row(CSR_START_ANGLE, 16'd16384));
      add_row(csr_row(CSR_ANGLE_STEP, 16'd16384));
      add_row(csr_row(CSR_MIN_RANGE_MM, 16'd100));
      add_row(csr_row(CSR_MAX_RANGE_MM, 16'd60000));
      add_row(csr_row(CSR_INF_AS_MAX, 16'd1));
      add_row(beam_row(16'd0, CLS_POS_INF, 1'b1));
      add_row(fixed_row(16'd99, CLS_FINITE, 1'b0, 0, 0, 1'b0));
      add_row(beam_row(16'd100, CLS_FINITE, 1'b0));
      add_row(beam_row(16'd60000, CLS_FINITE, 1'b0));
      add_row(fixed_row(16'd60001, CLS_FINITE, 1'b0, 0, 0, 1'b0));
      add_row(fixed_row(16'd5000, CLS_NAN, 1'b0, 0, 0, 1'b0));
      add_row(beam_row(16'd12345, CLS_FINITE, 1'b0));
      // zero max range: infinity is not mapped and stays rejected
      add_row(csr_row(CSR_MAX_RANGE_MM, 16'd0));
      add_row(csr_row(CSR_MIN_RANGE_MM, 16'd0));
      add_row(fixed_row(16'd0, CLS_POS_INF, 1'b0, 0, 0, 1'b0));
      add_row(beam_row(16'd0, CLS_FINITE, 1'b0));
      add_row(fixed_row(16'd1, CLS_FINITE, 1'b0, 0, 0, 1'b0));
      // top of the start angle and range registers, largest positive step
      add_row(csr_row(CSR_START_ANGLE, 16'hFFFF));
      add_row(csr_row(CSR_ANGLE_STEP, 16'h7FFF));
      add_row(csr_row(CSR_MAX_RANGE_MM, 16'hFFFF));
      add_row(csr_row(CSR_MIN_RANGE_MM, 16'hFFFF));
      add_row(beam_row(16'hFFFF, CLS_FINITE, 1'b1));
      add_row(fixed_row(16'hFFFE, CLS_FINITE, 1'b0, 0, 0, 1'b0));
      add_row(fixed_row(16'hFFFF, CLS_NEG_INF, 1'b0, 0, 0, 1'b0));
      // min above max
      add_row(csr_row(CSR_MIN_RANGE_MM, 16'd500));
      add_row(csr_row(CSR_MAX_RANGE_MM, 16'd400));
      add_row(fixed_row(16'd450, CLS_FINITE, 1'b0, 0, 0, 1'b0));
      // most negative step
      add_row(csr_row(CSR_ANGLE_STEP, 16'h8000));
      add_row(csr_row(CSR_START_ANGLE, 16'h2000));
      add_row(csr_row(CSR_MIN_RANGE_MM, 16'd0));
      add_row(csr_row(CSR_MAX_RANGE_MM, 16'hFFFF));
      add_row(csr_row(CSR_INF_AS_MAX, 16'd0));
      add_row(beam_row(16'd30000, CLS_FINITE, 1'b1));
      add_row(beam_row(16'hFFFF, CLS_FINITE, 1'b0));
      add_row(fixed_row(16'd7, CLS_POS_INF, 1'b0, 0, 0, 1'b0));
      add_row(beam_row(16'd1, CLS_FINITE, 1'b0));

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (plan[i]) begin
         row = plan[i];
         if (row.is_csr)
            write_reg(row.csr_idx, row.data);
         else
            drive_beam(row.range, row.cls, row.start, row.fixed, row.pt);
      end

      for (int phase = 0; phase < RAND_PHASES; phase++) begin
         case ($urandom_range(0, 3))
            0: data = 16'h0000;
            1: data = 16'hFFFF;
            default: data = 16'($urandom);
         endcase
         write_reg(CSR_START_ANGLE, data);
         case ($urandom_range(0, 5))
            0: data = 16'h8000;
            1: data = 16'h7FFF;
            2: data = 16'($urandom_range(1, 300));
            3: data = 16'h0000 - 16'($urandom_range(1, 300));
            4: data = 16'h0000;
            default: data = 16'($urandom);
         endcase
         write_reg(CSR_ANGLE_STEP, data);
         case ($urandom_range(0, 3))
            0: data = 16'h0000;
            1: data = 16'($urandom_range(0, 2000));
            default: data = 16'($urandom_range(0, 20000));
         endcase
         write_reg(CSR_MIN_RANGE_MM, data);
         case ($urandom_range(0, 9))
            0: data = 16'h0000;
            1: data = 16'($urandom);
            2, 3, 4: data = 16'hFFFF;
            default: data = 16'($urandom_range(cfg_min_mm, 65535));
         endcase
         write_reg(CSR_MAX_RANGE_MM, data);
         write_reg(CSR_INF_AS_MAX, 16'($urandom_range(0, 1)));

         // no idling in the last phase
         gap_on = (phase != RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
         stall_on = (phase != RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);

         for (int n = 0; n < PHASE_BEAMS; n++) begin
            case ($urandom_range(0, 9))
               0: v = 0;
               1: v = 65535;
               2: v = int'(cfg_min_mm) + int'($urandom_range(0, 4)) - 2;
               3: v = int'(cfg_max_mm) + int'($urandom_range(0, 4)) - 2;
               default: v = $urandom_range(0, 65535);
            endcase
            if (v < 0)
               v = 0;
            if (v > 65535)
               v = 65535;
            range = v[RANGE_W-1:0];
            case ($urandom_range(0, 9))
               7: cls = CLS_POS_INF;
               8: cls = CLS_NAN;
               9: cls = CLS_NEG_INF;
               default: cls = CLS_FINITE;
            endcase
            drive_beam(range, cls, $urandom_range(0, 19) == 0, 1'b0, '0);
         end
      end

      wait_for_points();
      repeat (40) @(posedge clock);
      $display("%0d beams sent, %0d points checked (%0d valid), %0d register writes",
               beams_sent, points_checked, valid_points, csr_writes);
      $display("covered range classes, range window edges, angle wrap and random back-pressure");
      if (error_count == 0 && pending_points.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
